// ===== hw/rtl/tgi_pkg.sv =====
package tgi_pkg;

	// fixed geometry
	localparam int GRID_AW   = 12;
	localparam int AXES      = 3;
	localparam int DIV_STEPS = 23;

	// input actions
	typedef enum logic [2:0] {
		ACT_LOAD_X,
		ACT_LOAD_Y,
		ACT_LOAD_Z,
		ACT_LOAD_GRID,
		ACT_QUERY
	} action_t;

	// configuration register indexes
	localparam logic [1:0] CFG_SIZE_X = 2'd0;
	localparam logic [1:0] CFG_SIZE_Y = 2'd1;
	localparam logic [1:0] CFG_SIZE_Z = 2'd2;

	// offset and value limits
	localparam logic [22:0] OFFS_LIM = 23'h400000;
	localparam logic signed [49:0] WIDE_MAX = 50'sd1099511627775;
	localparam logic signed [49:0] WIDE_MIN = -50'sd1099511627776;
	localparam logic signed [40:0] OUT_MAX  = 41'sd2147483647;
	localparam logic signed [40:0] OUT_MIN  = -41'sd2147483648;

	// unit-cube coefficient matrix, row r gives coefficient r from the corners
	localparam logic signed [1:0] CUBE_MAT [0:7][0:7] = '{
		'{ 2'sd1,  2'sd0,  2'sd0,  2'sd0,  2'sd0,  2'sd0,  2'sd0, 2'sd0},
		'{-2'sd1,  2'sd1,  2'sd0,  2'sd0,  2'sd0,  2'sd0,  2'sd0, 2'sd0},
		'{-2'sd1,  2'sd0,  2'sd1,  2'sd0,  2'sd0,  2'sd0,  2'sd0, 2'sd0},
		'{ 2'sd1, -2'sd1, -2'sd1,  2'sd1,  2'sd0,  2'sd0,  2'sd0, 2'sd0},
		'{-2'sd1,  2'sd0,  2'sd0,  2'sd0,  2'sd1,  2'sd0,  2'sd0, 2'sd0},
		'{ 2'sd1, -2'sd1,  2'sd0,  2'sd0, -2'sd1,  2'sd1,  2'sd0, 2'sd0},
		'{ 2'sd1,  2'sd0, -2'sd1,  2'sd0, -2'sd1,  2'sd0,  2'sd1, 2'sd0},
		'{-2'sd1,  2'sd1,  2'sd1, -2'sd1,  2'sd1, -2'sd1, -2'sd1, 2'sd1}
	};

	// evaluation steps of the nested polynomial
	typedef enum logic [2:0] {
		LS_Z0,
		LS_Z1,
		LS_Y0,
		LS_Z2,
		LS_Z3,
		LS_Y1,
		LS_X
	} lerp_step_t;

	// sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_START,
		S_SCAN_LO,
		S_SCAN_NXT,
		S_DIV_START,
		S_DIV_WAIT,
		S_GRID_PREP,
		S_GRID_RD,
		S_GRID_LAST,
		S_COEF,
		S_LERP_MUL,
		S_LERP_ADD,
		S_DONE
	} seq_state_t;

	// divider states
	typedef enum logic [1:0] {
		D_IDLE,
		D_CHECK,
		D_RUN,
		D_DONE
	} div_state_t;

	typedef struct packed {
		logic               done;
		logic               sat;
		logic signed [23:0] quot;
	} div_res_t;

	typedef struct packed {
		logic               sat;
		logic signed [40:0] res;
	} lerp_res_t;

endpackage

// ===== hw/rtl/tgi_divider.sv =====
module tgi_divider import tgi_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [48:0] num,
	input  logic        [31:0] den,
	output div_res_t           res
);

	div_state_t dstate_q, dstate_d;
	logic [48:0] mag_q;
	logic [22:0] low_q;
	logic [31:0] den_q;
	logic [31:0] rem_q;
	logic [22:0] quo_q;
	logic [4:0]  cnt_q;
	logic        neg_q;
	logic        over_q;

	logic        over_now;
	logic [32:0] rem_sh;
	logic        rem_ge;
	logic        clip;
	logic [22:0] mag_out;

	// overflow when the quotient needs more than 23 bits
	assign over_now = {6'b0, mag_q[48:23]} >= den_q;
	assign rem_sh   = {rem_q, low_q[22]};
	assign rem_ge   = rem_sh >= {1'b0, den_q};

	// next state
	always_comb begin
		dstate_d = dstate_q;
		case (dstate_q)
			D_IDLE:  if (start) dstate_d = D_CHECK;
			D_CHECK: dstate_d = over_now ? D_DONE : D_RUN;
			D_RUN:   if (cnt_q == 5'd0) dstate_d = D_DONE;
			D_DONE:  dstate_d = D_IDLE;
			default: dstate_d = D_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dstate_q <= D_IDLE;
		end else begin
			dstate_q <= dstate_d;
		end
	end

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk) begin
		case (dstate_q)
			D_IDLE: begin
				neg_q <= num[48];
				mag_q <= num[48] ? 49'(-num) : num;
				den_q <= den;
			end
			D_CHECK: begin
				over_q <= over_now;
				rem_q  <= {6'b0, mag_q[48:23]};
				low_q  <= mag_q[22:0];
				quo_q  <= '0;
				cnt_q  <= 5'(DIV_STEPS - 1);
			end
			D_RUN: begin
				rem_q <= rem_ge ? 32'(rem_sh - {1'b0, den_q}) : rem_sh[31:0];
				quo_q <= {quo_q[21:0], rem_ge};
				low_q <= {low_q[21:0], 1'b0};
				cnt_q <= cnt_q - 5'd1;
			end
			default: begin
			end
		endcase
	end

	// signed, clipped result
	always_comb begin
		clip        = over_q || (quo_q > OFFS_LIM);
		mag_out     = clip ? OFFS_LIM : quo_q;
		res.done    = (dstate_q == D_DONE);
		res.sat     = clip;
		res.quot    = neg_q ? -$signed({1'b0, mag_out}) : $signed({1'b0, mag_out});
	end

endmodule

// ===== hw/rtl/tgi_lerp.sv =====
module tgi_lerp import tgi_pkg::*; (
	input  logic               clk,
	input  logic signed [40:0] a,
	input  logic signed [40:0] b,
	input  logic signed [23:0] t,
	output lerp_res_t          res
);

	logic signed [64:0] prod_s1;
	logic signed [49:0] sum;

	// product stage
	always_ff @(posedge clk) begin
		prod_s1 <= b * t;
	end

	// floor of product over 2^16, add and clip to the wide range
	always_comb begin
		sum = {{9{a[40]}}, a} + {prod_s1[64], prod_s1[64:16]};
		if (sum > WIDE_MAX) begin
			res.sat = 1'b1;
			res.res = WIDE_MAX[40:0];
		end else if (sum < WIDE_MIN) begin
			res.sat = 1'b1;
			res.res = WIDE_MIN[40:0];
		end else begin
			res.sat = 1'b0;
			res.res = sum[40:0];
		end
	end

endmodule

// ===== hw/rtl/trilinear_grid_interpolator.sv =====
// Trilinear interpolator over a rectilinear 3-D grid, signed Q16.16.
// Input channel (in_valid/in_stall): action, load_index, load_data and a
// query point. Actions 0..2 write an axis coordinate, 3 writes a grid
// value, 4 runs a query; loads give no result.
// Output channel (out_valid/out_stall): one interpolated value and a
// saturated flag per query. Config channel (cfg_valid/cfg_ready, always
// ready): cfg_index 0..2 selects size_x, size_y, size_z; write when idle.
// During a query each axis is scanned one coordinate per cycle through the
// coordinate memory port, each cell offset over a positive cell width goes
// through the bit-serial divider (23 steps plus setup), the eight corners
// are read one per cycle from the grid memory, and seven multiply-add steps
// share one multiplier. The block takes no new item while a query runs;
// a finished result sits in the output register, so the next item is
// accepted while the receiver stalls, and a following query waits at its
// end for that register. Reset returns the sequencer to idle, drops
// out_valid and sets all three sizes to 2; coordinate and grid memories
// keep no reset value.
module trilinear_grid_interpolator import tgi_pkg::*; #(
	parameter int MAX_AXIS_POINTS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         action,
	input  logic [11:0]        load_index,
	input  logic signed [31:0] load_data,
	input  logic signed [31:0] query_x,
	input  logic signed [31:0] query_y,
	input  logic signed [31:0] query_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] interpolated,
	output logic               saturated,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [4:0]         cfg_data
);

	localparam int AW     = $clog2(MAX_AXIS_POINTS);
	localparam int SW     = $clog2(MAX_AXIS_POINTS + 1);
	localparam int CW     = SW + 1;
	localparam int CDEPTH = 3 * (2 ** AW);

	seq_state_t state_q, state_d;

	// configuration
	logic [4:0] size_x_q, size_y_q, size_z_q;
	logic [SW-1:0] nx, ny, nz, n_cur;

	// memories
	logic signed [31:0] coord_mem [0:CDEPTH-1];
	logic signed [31:0] grid_mem [0:(2**GRID_AW)-1];
	logic signed [31:0] coord_rd_q, grid_rd_q;
	logic [AW+1:0]      coord_waddr, coord_raddr;
	logic [AW-1:0]      rd_idx;
	logic [GRID_AW-1:0] grid_raddr;
	logic               coord_we, grid_we;

	// query working registers
	logic signed [31:0] qx_q, qy_q, qz_q, q_cur;
	logic [1:0]         ax_q;
	logic [AW-1:0]      idx_q, cur_lo_q, cur_hi_q;
	logic signed [31:0] lower_q, upper_q;
	logic [AW-1:0]      lo_idx_q [0:AXES-1];
	logic [AW-1:0]      hi_idx_q [0:AXES-1];
	logic signed [23:0] t_q [0:AXES-1];
	logic [GRID_AW-1:0] stride_q;
	logic [GRID_AW-1:0] xo_q [0:1];
	logic [GRID_AW-1:0] yo_q [0:1];
	logic [2:0]         corner_q;
	logic signed [31:0] v_q [0:7];
	logic signed [35:0] k_q [0:7];
	logic signed [35:0] k_d [0:7];
	logic signed [40:0] w_q [0:6];
	lerp_step_t         step_q;
	logic               sat_q;
	logic               out_valid_q;
	logic signed [31:0] interpolated_q;
	logic               saturated_q;

	logic               accept;
	logic               last_axis;
	logic               adv;
	logic               more;
	logic signed [32:0] den33;
	logic               den_pos;
	logic signed [48:0] num49;
	logic               div_start;
	div_res_t           div_res;
	logic signed [40:0] la, lb;
	logic signed [23:0] lt;
	lerp_res_t          lerp_res;
	logic               out_load;
	logic signed [40:0] f_val;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;
	assign out_valid    = out_valid_q;
	assign interpolated = interpolated_q;
	assign saturated    = saturated_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= 5'd2;
			size_y_q <= 5'd2;
			size_z_q <= 5'd2;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SIZE_X: size_x_q <= cfg_data;
				CFG_SIZE_Y: size_y_q <= cfg_data;
				CFG_SIZE_Z: size_z_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// effective sizes, clamped to 1..MAX_AXIS_POINTS
	function automatic logic [SW-1:0] eff_size(input logic [4:0] s);
		logic [SW-1:0] r;
		if (s == 5'd0) r = SW'(1);
		else if (32'(s) > MAX_AXIS_POINTS) r = SW'(MAX_AXIS_POINTS);
		else r = SW'(s);
		return r;
	endfunction

	assign nx = eff_size(size_x_q);
	assign ny = eff_size(size_y_q);
	assign nz = eff_size(size_z_q);

	// per-axis selection
	always_comb begin
		case (ax_q)
			2'd0: begin
				q_cur = qx_q;
				n_cur = nx;
			end
			2'd1: begin
				q_cur = qy_q;
				n_cur = ny;
			end
			default: begin
				q_cur = qz_q;
				n_cur = nz;
			end
		endcase
	end

	assign last_axis = (ax_q == 2'(AXES - 1));
	assign adv  = (coord_rd_q <= q_cur);
	assign more = (CW'(idx_q) + CW'(2)) < CW'(n_cur);

	// cell width and scaled offset numerator
	assign den33   = {upper_q[31], upper_q} - {lower_q[31], lower_q};
	assign den_pos = !den33[32] && (den33 != 33'sd0);
	assign num49   = {({q_cur[31], q_cur} - {lower_q[31], lower_q}), 16'b0};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:       if (accept && action == ACT_QUERY) state_d = S_SCAN_START;
			S_SCAN_START: state_d = S_SCAN_LO;
			S_SCAN_LO:    state_d = (n_cur > SW'(1)) ? S_SCAN_NXT : S_DIV_START;
			S_SCAN_NXT:   state_d = (adv && more) ? S_SCAN_NXT : S_DIV_START;
			S_DIV_START: begin
				if (den_pos) state_d = S_DIV_WAIT;
				else state_d = last_axis ? S_GRID_PREP : S_SCAN_START;
			end
			S_DIV_WAIT: begin
				if (div_res.done) state_d = last_axis ? S_GRID_PREP : S_SCAN_START;
			end
			S_GRID_PREP:  state_d = S_GRID_RD;
			S_GRID_RD:    if (corner_q == 3'd7) state_d = S_GRID_LAST;
			S_GRID_LAST:  state_d = S_COEF;
			S_COEF:       state_d = S_LERP_MUL;
			S_LERP_MUL:   state_d = S_LERP_ADD;
			S_LERP_ADD:   state_d = (step_q == LS_X) ? S_DONE : S_LERP_MUL;
			S_DONE:       if (!out_valid_q || !out_stall) state_d = S_IDLE;
			default:      state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall  = (state_q != S_IDLE);
		div_start = (state_q == S_DIV_START) && den_pos;
		out_load  = (state_q == S_DONE) && (!out_valid_q || !out_stall);
		case (state_q)
			S_SCAN_LO:  rd_idx = AW'(1);
			S_SCAN_NXT: rd_idx = idx_q + AW'(2);
			default:    rd_idx = '0;
		endcase
		coord_we    = accept && (action inside {ACT_LOAD_X, ACT_LOAD_Y, ACT_LOAD_Z}) &&
			(load_index < 12'(MAX_AXIS_POINTS));
		grid_we     = accept && (action == ACT_LOAD_GRID);
		coord_waddr = {action[1:0], load_index[AW-1:0]};
		coord_raddr = {ax_q, rd_idx};
		grid_raddr  = xo_q[corner_q[2]] + yo_q[corner_q[1]] +
			GRID_AW'(corner_q[0] ? hi_idx_q[2] : lo_idx_q[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// coordinate memory
	always_ff @(posedge clk) begin
		if (coord_we) coord_mem[coord_waddr] <= load_data;
		coord_rd_q <= coord_mem[coord_raddr];
	end

	// grid memory
	always_ff @(posedge clk) begin
		if (grid_we) grid_mem[load_index] <= load_data;
		grid_rd_q <= grid_mem[grid_raddr];
	end

	// shared offset divider
	tgi_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num49),
		.den    (den33[31:0]),
		.res    (div_res)
	);

	// coefficients from the eight corners
	always_comb begin
		for (int r = 0; r < 8; r++) begin
			k_d[r] = '0;
			for (int c = 0; c < 8; c++) begin
				if (CUBE_MAT[r][c] == 2'sd1) k_d[r] = k_d[r] + 36'(v_q[c]);
				else if (CUBE_MAT[r][c] == -2'sd1) k_d[r] = k_d[r] - 36'(v_q[c]);
			end
		end
	end

	// operands of the nested evaluation
	always_comb begin
		case (step_q)
			LS_Z0: begin
				la = 41'(k_q[0]);
				lb = 41'(k_q[1]);
				lt = t_q[2];
			end
			LS_Z1: begin
				la = 41'(k_q[2]);
				lb = 41'(k_q[3]);
				lt = t_q[2];
			end
			LS_Y0: begin
				la = w_q[0];
				lb = w_q[1];
				lt = t_q[1];
			end
			LS_Z2: begin
				la = 41'(k_q[4]);
				lb = 41'(k_q[5]);
				lt = t_q[2];
			end
			LS_Z3: begin
				la = 41'(k_q[6]);
				lb = 41'(k_q[7]);
				lt = t_q[2];
			end
			LS_Y1: begin
				la = w_q[3];
				lb = w_q[4];
				lt = t_q[1];
			end
			LS_X: begin
				la = w_q[2];
				lb = w_q[5];
				lt = t_q[0];
			end
			default: begin
				la = '0;
				lb = '0;
				lt = '0;
			end
		endcase
	end

	tgi_lerp u_lerp (
		.clk (clk),
		.a   (la),
		.b   (lb),
		.t   (lt),
		.res (lerp_res)
	);

	// query datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					qx_q     <= query_x;
					qy_q     <= query_y;
					qz_q     <= query_z;
					stride_q <= GRID_AW'(ny) * GRID_AW'(nz);
					ax_q     <= '0;
					sat_q    <= 1'b0;
				end
			end
			S_SCAN_LO: begin
				lower_q  <= coord_rd_q;
				upper_q  <= coord_rd_q;
				idx_q    <= '0;
				cur_lo_q <= '0;
				cur_hi_q <= '0;
			end
			S_SCAN_NXT: begin
				upper_q <= coord_rd_q;
				if (adv) begin
					lower_q  <= coord_rd_q;
					idx_q    <= idx_q + AW'(1);
					cur_lo_q <= idx_q + AW'(1);
					cur_hi_q <= idx_q + AW'(1);
				end else begin
					cur_lo_q <= idx_q;
					cur_hi_q <= idx_q + AW'(1);
				end
			end
			S_DIV_START: begin
				lo_idx_q[ax_q] <= cur_lo_q;
				hi_idx_q[ax_q] <= cur_hi_q;
				if (!den_pos) begin
					t_q[ax_q] <= '0;
					if (!last_axis) ax_q <= ax_q + 2'd1;
				end
			end
			S_DIV_WAIT: begin
				if (div_res.done) begin
					t_q[ax_q] <= div_res.quot;
					sat_q     <= sat_q | div_res.sat;
					if (!last_axis) ax_q <= ax_q + 2'd1;
				end
			end
			S_GRID_PREP: begin
				xo_q[0]  <= GRID_AW'(lo_idx_q[0]) * stride_q;
				xo_q[1]  <= GRID_AW'(hi_idx_q[0]) * stride_q;
				yo_q[0]  <= GRID_AW'(lo_idx_q[1]) * GRID_AW'(nz);
				yo_q[1]  <= GRID_AW'(hi_idx_q[1]) * GRID_AW'(nz);
				corner_q <= '0;
			end
			S_GRID_RD: begin
				if (corner_q != 3'd0) v_q[corner_q - 3'd1] <= grid_rd_q;
				corner_q <= corner_q + 3'd1;
			end
			S_GRID_LAST: begin
				v_q[7] <= grid_rd_q;
			end
			S_COEF: begin
				for (int r = 0; r < 8; r++) k_q[r] <= k_d[r];
				step_q <= LS_Z0;
			end
			S_LERP_ADD: begin
				w_q[step_q] <= lerp_res.res;
				sat_q       <= sat_q | lerp_res.sat;
				step_q      <= lerp_step_t'(step_q + 3'd1);
			end
			default: begin
			end
		endcase
	end

	// final clip to 32 bits
	assign f_val = w_q[6];

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (f_val > OUT_MAX) begin
				interpolated_q <= OUT_MAX[31:0];
				saturated_q    <= 1'b1;
			end else if (f_val < OUT_MIN) begin
				interpolated_q <= OUT_MIN[31:0];
				saturated_q    <= 1'b1;
			end else begin
				interpolated_q <= f_val[31:0];
				saturated_q    <= sat_q;
			end
		end
	end

	// output transaction register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// a result appears only after the sequencer finished a query
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result without finished query");

	// upper cell index is the lower one or the next
	a_cell_span: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV_START) |->
		(cur_hi_q == cur_lo_q) || (cur_hi_q == cur_lo_q + AW'(1)))
		else $error("cell upper index out of step");

	// divider completion moves on to the next axis or the corner reads
	a_div_next: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV_WAIT && div_res.done) |=>
		(state_q == S_SCAN_START || state_q == S_GRID_PREP))
		else $error("divider completion lost");

	// each axis start finds the divider idle
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN_START) |-> !div_res.done)
		else $error("divider busy at axis start");

endmodule

// ===== tb/sv/tgi_checker.sv =====
module tgi_checker import tgi_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [2:0]         action,
	input  logic [11:0]        load_index,
	input  logic signed [31:0] load_data,
	input  logic signed [31:0] query_x,
	input  logic signed [31:0] query_y,
	input  logic signed [31:0] query_z,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] interpolated,
	input  logic               saturated,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [4:0]         cfg_data,
	output int                 fails,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int AXIS_DEPTH = 16;
	localparam int GRID_DEPTH = 1 << GRID_AW;

	typedef struct {
		logic signed [31:0] value;
		logic               sat;
	} interp_t;

	interp_t queued_interp[$];
	longint  axis_tab [AXES][AXIS_DEPTH];
	longint  grid_mem [GRID_DEPTH];
	logic [4:0] size_reg [AXES];
	bit      clipped;

	initial begin
		fails = 0;
		pending = 0;
		foreach (axis_tab[a, i]) axis_tab[a][i] = 0;
		foreach (grid_mem[i]) grid_mem[i] = 0;
	end

	// size register as the datapath sees it
	function automatic int used_points(logic [4:0] s);
		if (s == 0) return 1;
		if (s > AXIS_DEPTH) return AXIS_DEPTH;
		return int'(s);
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		if (v < lo) begin
			clipped = 1;
			return lo;
		end
		if (v > hi) begin
			clipped = 1;
			return hi;
		end
		return v;
	endfunction

	// a + b*t in Q16.16, product floored
	function automatic longint lerp(longint a, longint b, longint t);
		return clamp(a + ((b * t) >>> 16), longint'(WIDE_MIN), longint'(WIDE_MAX));
	endfunction

	// scan one axis for its cell and normalized offset
	function automatic void find_cell(int ax, longint q, output int lo_i, output int hi_i,
			output longint t);
		int n;
		longint den;
		n = used_points(size_reg[ax]);
		lo_i = 0;
		while (lo_i + 1 < n && axis_tab[ax][lo_i + 1] <= q) lo_i++;
		hi_i = (lo_i + 1 < n) ? lo_i + 1 : lo_i;
		den = axis_tab[ax][hi_i] - axis_tab[ax][lo_i];
		if (den <= 0) t = 0;
		else t = clamp(((q - axis_tab[ax][lo_i]) * 65536) / den,
			-longint'(OFFS_LIM), longint'(OFFS_LIM));
	endfunction

	function automatic interp_t interpolate_point(longint qx, longint qy, longint qz);
		int xl, xh, yl, yh, zl, zh, ny, nz, i, j, m;
		longint tx, ty, tz, a, b, lo, d, e, hi, f;
		longint corner [8];
		longint coef [8];
		interp_t r;
		clipped = 0;
		ny = used_points(size_reg[1]);
		nz = used_points(size_reg[2]);
		find_cell(0, qx, xl, xh, tx);
		find_cell(1, qy, yl, yh, ty);
		find_cell(2, qz, zl, zh, tz);
		for (int c = 0; c < 8; c++) begin
			i = c[2] ? xh : xl;
			j = c[1] ? yh : yl;
			m = c[0] ? zh : zl;
			corner[c] = grid_mem[((i * ny + j) * nz + m) & (GRID_DEPTH - 1)];
		end
		for (int k = 0; k < 8; k++) begin
			coef[k] = 0;
			for (int c = 0; c < 8; c++) coef[k] += longint'(CUBE_MAT[k][c]) * corner[c];
		end
		// nested evaluation, z then y then x
		a = lerp(coef[0], coef[1], tz);
		b = lerp(coef[2], coef[3], tz);
		lo = lerp(a, b, ty);
		d = lerp(coef[4], coef[5], tz);
		e = lerp(coef[6], coef[7], tz);
		hi = lerp(d, e, ty);
		f = lerp(lo, hi, tx);
		f = clamp(f, longint'(OUT_MIN), longint'(OUT_MAX));
		r.value = f[31:0];
		r.sat = clipped;
		return r;
	endfunction

	// watch all three channels
	always @(posedge clk or negedge arst_n) begin
		interp_t exp_r;
		if (!arst_n) begin
			foreach (size_reg[a]) size_reg[a] = 5'd2;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SIZE_X: size_reg[0] = cfg_data;
					CFG_SIZE_Y: size_reg[1] = cfg_data;
					CFG_SIZE_Z: size_reg[2] = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				case (action_t'(action))
					ACT_LOAD_X, ACT_LOAD_Y, ACT_LOAD_Z: begin
						if (load_index < AXIS_DEPTH)
							axis_tab[int'(action)][load_index] = longint'(load_data);
					end
					ACT_LOAD_GRID: grid_mem[load_index] = longint'(load_data);
					ACT_QUERY: queued_interp.insert(queued_interp.size(),
						interpolate_point(query_x, query_y, query_z));
					default: ;
				endcase
			end
			// result transaction against the oldest prediction
			if (out_valid && !out_stall) begin
				if (queued_interp.size() == 0) begin
					fails++;
					$display("%0t: unexpected result interpolated=%0d saturated=%0b",
						$time, interpolated, saturated);
				end else begin
					exp_r = queued_interp.pop_front();
					if (interpolated !== exp_r.value) begin
						fails++;
						$display("%0t: interpolated expected %0d actual %0d",
							$time, exp_r.value, interpolated);
					end
					if (saturated !== exp_r.sat) begin
						fails++;
						$display("%0t: saturated expected %0b actual %0b",
							$time, exp_r.sat, saturated);
					end
				end
			end
			pending = queued_interp.size();
		end
	end

endmodule

// ===== tb/sv/trilinear_grid_interpolator_tb.sv =====
module trilinear_grid_interpolator_tb import tgi_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  AXIS_DEPTH = 16;
	localparam int  ONE = 65536;
	localparam int  SETTLE = 200;
	localparam int  ITEM_TARGET = 750;
	localparam int  CALM_AFTER = 650;
	localparam logic [31:0] VAL_MAX = 32'h7fff_ffff;
	localparam logic [31:0] VAL_MIN = 32'h8000_0000;
	localparam logic [2:0]  ACT_FIRST_UNUSED = 3'(ACT_QUERY) + 3'd1;
	localparam logic [2:0]  ACT_LAST_UNUSED = 3'h7;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [2:0]         action;
	logic [11:0]        load_index;
	logic signed [31:0] load_data;
	logic signed [31:0] query_x;
	logic signed [31:0] query_y;
	logic signed [31:0] query_z;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] interpolated;
	logic               saturated;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [4:0]         cfg_data;
	int                 fails;
	int                 pending;

	bit  calm;
	int  items_sent;
	int  queries_sent;
	int  settings_run;
	int  stall_left;
	logic signed [31:0] axis_copy [3][AXIS_DEPTH];
	int  axis_n [3];

	trilinear_grid_interpolator dut (.*);

	tgi_checker checker_i (.*);

	initial clk = 0;
	always #4 clk = ~clk;

	// receiver stalls in random bursts
	initial begin
		out_stall = 0;
		stall_left = 0;
	end
	always @(negedge clk) begin
		if (calm) begin
			out_stall = 0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall = 1;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 10);
			out_stall = 1;
		end else begin
			out_stall = 0;
		end
	end

	// one input transaction, with an occasional idle burst ahead of it
	task automatic push_item(logic [2:0] act, logic [11:0] idx, logic [31:0] data,
			logic [31:0] qx, logic [31:0] qy, logic [31:0] qz);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid = 0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		action = act;
		load_index = idx;
		load_data = data;
		query_x = qx;
		query_y = qy;
		query_z = qz;
		in_valid = 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		if (act == ACT_QUERY) queries_sent++;
		if (act <= ACT_QUERY && !(act < ACT_LOAD_GRID && idx >= AXIS_DEPTH)) items_sent++;
		if (items_sent > CALM_AFTER) calm = 1;
	endtask

	// idle until every result is back and the block has settled
	task automatic drain();
		in_valid = 0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_size(logic [1:0] idx, logic [4:0] val);
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	function automatic int used_points(logic [4:0] s);
		if (s == 0) return 1;
		if (s > AXIS_DEPTH) return AXIS_DEPTH;
		return int'(s);
	endfunction

	task automatic apply_sizes(logic [4:0] sx, logic [4:0] sy, logic [4:0] sz);
		drain();
		write_size(CFG_SIZE_X, sx);
		write_size(CFG_SIZE_Y, sy);
		write_size(CFG_SIZE_Z, sz);
		axis_n[0] = used_points(sx);
		axis_n[1] = used_points(sy);
		axis_n[2] = used_points(sz);
		settings_run++;
	endtask

	function automatic logic [31:0] grid_value();
		case ($urandom_range(0, 7))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
			default: return 32'($urandom_range(0, 1 << 24)) - 32'(1 << 23);
		endcase
	endfunction

	// coordinates: mostly ascending with some flat cells, sometimes arbitrary
	task automatic load_axis(int ax);
		bit wild;
		longint c;
		wild = ($urandom_range(0, 11) == 0);
		c = longint'($urandom_range(0, 10 * ONE)) - 5 * ONE;
		for (int i = 0; i < axis_n[ax]; i++) begin
			if (wild) axis_copy[ax][i] = $urandom;
			else axis_copy[ax][i] = c[31:0];
			push_item(3'(ax), 12'(i), axis_copy[ax][i], $urandom, $urandom, $urandom);
			if ($urandom_range(0, 5) != 0) c += $urandom_range(1, 3 * ONE);
		end
	endtask

	function automatic logic [31:0] pick_point(int ax);
		longint lo, hi, span;
		lo = axis_copy[ax][0];
		hi = lo;
		for (int i = 1; i < axis_n[ax]; i++) begin
			if (axis_copy[ax][i] < lo) lo = axis_copy[ax][i];
			if (axis_copy[ax][i] > hi) hi = axis_copy[ax][i];
		end
		span = hi - lo + 2 * ONE;
		case ($urandom_range(0, 9))
			6, 7: return axis_copy[ax][$urandom_range(0, axis_n[ax] - 1)];
			8: return $urandom;
			9: return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
			default: begin
				if (span > longint'(32'hffff_ffff)) return $urandom;
				lo = lo - ONE + longint'($urandom_range(0, 32'(span)));
				return lo[31:0];
			end
		endcase
	endfunction

	task automatic run_setting(logic [4:0] sx, logic [4:0] sy, logic [4:0] sz);
		int cells;
		apply_sizes(sx, sy, sz);
		for (int a = 0; a < 3; a++) load_axis(a);
		cells = axis_n[0] * axis_n[1] * axis_n[2];
		for (int i = 0; i < cells; i++)
			push_item(ACT_LOAD_GRID, 12'(i), grid_value(), $urandom, $urandom, $urandom);
		repeat ($urandom_range(15, 40)) begin
			case ($urandom_range(0, 19))
				0: push_item(3'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST_UNUSED)),
					12'($urandom), $urandom, $urandom, $urandom, $urandom);
				1: push_item(3'($urandom_range(ACT_LOAD_X, ACT_LOAD_Z)),
					12'($urandom_range(AXIS_DEPTH, 4095)), $urandom, $urandom, $urandom,
					$urandom);
				2: push_item(ACT_LOAD_GRID, 12'($urandom), grid_value(), $urandom, $urandom,
					$urandom);
				default: push_item(ACT_QUERY, 12'($urandom), $urandom, pick_point(0),
					pick_point(1), pick_point(2));
			endcase
		end
	endtask

	function automatic logic [4:0] random_size();
		case ($urandom_range(0, 15))
			0: return 5'd0;
			1: return 5'($urandom_range(AXIS_DEPTH + 1, 31));
			default: return 5'($urandom_range(1, 5));
		endcase
	endfunction

	initial begin
		logic [4:0] sx, sy, sz;
		arst_n = 0;
		in_valid = 0;
		action = ACT_LOAD_X;
		load_index = 0;
		load_data = 0;
		query_x = 0;
		query_y = 0;
		query_z = 0;
		cfg_valid = 0;
		cfg_index = CFG_SIZE_X;
		cfg_data = 0;
		calm = 0;
		items_sent = 0;
		queries_sent = 0;
		settings_run = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: one cell at reset sizes, two corners at the value extremes
		axis_n = '{2, 2, 2};
		push_item(ACT_LOAD_X, 0, 0, 0, 0, 0);
		push_item(ACT_LOAD_X, 1, ONE, 0, 0, 0);
		push_item(ACT_LOAD_Y, 0, 0, 0, 0, 0);
		push_item(ACT_LOAD_Y, 1, ONE, 0, 0, 0);
		push_item(ACT_LOAD_Z, 0, -ONE, 0, 0, 0);
		push_item(ACT_LOAD_Z, 1, ONE, 0, 0, 0);
		push_item(ACT_LOAD_X, 12'hfff, VAL_MAX, 0, 0, 0);
		for (int i = 0; i < 8; i++)
			push_item(ACT_LOAD_GRID, 12'(i), (i == 3) ? VAL_MAX : (i == 4) ? VAL_MIN :
				32'(i * ONE), 0, 0, 0);
		push_item(ACT_FIRST_UNUSED, 0, 0, 0, 0, 0);
		push_item(ACT_LAST_UNUSED, 12'hfff, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN);
		push_item(ACT_QUERY, 0, 0, ONE / 2, ONE / 2, 0);
		push_item(ACT_QUERY, 0, 0, 0, 0, -ONE);
		push_item(ACT_QUERY, 0, 0, -ONE, -ONE / 4, -3 * ONE);
		push_item(ACT_QUERY, 0, 0, 5 * ONE, 2 * ONE, 9 * ONE);
		push_item(ACT_QUERY, 0, 0, VAL_MIN, VAL_MAX, 0);
		push_item(ACT_QUERY, 0, 0, VAL_MIN, VAL_MIN, VAL_MIN);

		// one axis at a time at full length, then the out-of-range encodings and a 4x4x4 grid
		run_setting(5'd16, 5'd1, 5'd1);
		run_setting(5'd1, 5'd16, 5'd1);
		run_setting(5'd1, 5'd1, 5'd16);
		run_setting(5'd0, 5'd31, 5'd2);
		run_setting(5'd31, 5'd0, 5'd0);
		run_setting(5'd4, 5'd4, 5'd4);

		while (items_sent < ITEM_TARGET) begin
			do begin
				sx = random_size();
				sy = random_size();
				sz = random_size();
			end while (used_points(sx) * used_points(sy) * used_points(sz) > 256);
			run_setting(sx, sy, sz);
		end

		drain();
		$display("%0d items, %0d queries over %0d grid size settings", items_sent,
			queries_sent, settings_run + 1);
		if (fails == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
